// ===== hdl/tbi_pkg.sv =====
// Shared widths, register indexes and limits of the broadcast index generator.
`timescale 1ns / 1ps

package tbi_pkg;

  // Default width of the index arithmetic.
  localparam int INDEX_BITS_DEFAULT = 32;

  // Field widths.
  localparam int TILE_NUMBER_W   = 31;
  localparam int ELEM_POSITION_W = 20;
  localparam int SRC_INDEX_W     = 31;
  localparam int TILE_LENGTH_W   = 21;
  localparam int EXTENT_W        = 17;

  // Configuration port.
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_LENGTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_EXTENT_0 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_EXTENT_1 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_EXTENT_2 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_EXTENT_3 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_EXTENT_0 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_EXTENT_1 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_EXTENT_2 = 4'd7;

  // Largest intermediate value that does not raise the overflow flag.
  localparam logic [63:0] SAFE_LIMIT = 64'h0000_0000_7FFF_FFFF;

endpackage

// ===== hdl/tbi_cell.sv =====
// One restoring division step for several independent lanes.
`timescale 1ns / 1ps

module tbi_cell #(
  parameter int WIDTH  = tbi_pkg::INDEX_BITS_DEFAULT,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [SIDE_W-1:0]            side_i,
  input  logic [LANES-1:0][WIDTH-1:0]  rem_i,
  input  logic [LANES-1:0][WIDTH-1:0]  num_i,
  input  logic [LANES-1:0][WIDTH-1:0]  div_i,
  output logic                         valid_o,
  output logic [SIDE_W-1:0]            side_o,
  output logic [LANES-1:0][WIDTH-1:0]  rem_o,
  output logic [LANES-1:0][WIDTH-1:0]  num_o
);

  logic                        valid_q;
  logic [SIDE_W-1:0]           side_q;
  logic [LANES-1:0][WIDTH-1:0] rem_d, rem_q;
  logic [LANES-1:0][WIDTH-1:0] num_d, num_q;

  // Shift the next dividend bit into the partial remainder and subtract when it fits.
  // For a nonzero divisor the remainder stays below the divisor, so it fits in WIDTH bits.
  always_comb begin
    logic [WIDTH:0] trial;
    logic           qbit;
    trial = '0;
    qbit  = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      trial = {rem_i[l], num_i[l][WIDTH-1]};
      qbit  = (trial >= {1'b0, div_i[l]});
      if (qbit) begin
        rem_d[l] = WIDTH'(trial - {1'b0, div_i[l]});
      end else begin
        rem_d[l] = trial[WIDTH-1:0];
      end
      num_d[l] = {num_i[l][WIDTH-2:0], qbit};
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload moves on every cycle.
  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    rem_q  <= rem_d;
    num_q  <= num_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;

endmodule

// ===== hdl/tbi_chain.sv =====
// A row of division cells that yields quotient and remainder.
`timescale 1ns / 1ps

module tbi_chain #(
  parameter int WIDTH  = tbi_pkg::INDEX_BITS_DEFAULT,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [SIDE_W-1:0]            side_i,
  input  logic [LANES-1:0][WIDTH-1:0]  dividend_i,
  input  logic [LANES-1:0][WIDTH-1:0]  divisor_i,
  output logic                         valid_o,
  output logic [SIDE_W-1:0]            side_o,
  output logic [LANES-1:0][WIDTH-1:0]  quot_o,
  output logic [LANES-1:0][WIDTH-1:0]  rem_o
);

  logic [WIDTH:0]                        vld;
  logic [WIDTH:0][SIDE_W-1:0]            side;
  logic [WIDTH:0][LANES-1:0][WIDTH-1:0]  rem;
  logic [WIDTH:0][LANES-1:0][WIDTH-1:0]  num;

  // The first cell starts from a zero remainder with the whole dividend to shift in.
  assign vld[0]  = valid_i;
  assign side[0] = side_i;
  assign rem[0]  = '0;
  assign num[0]  = dividend_i;

  // One quotient bit per cell, most significant first. A zero divisor gives
  // an all-ones quotient and leaves the dividend as the remainder.
  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    tbi_cell #(
      .WIDTH  (WIDTH),
      .LANES  (LANES),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .side_i  (side[k]),
      .rem_i   (rem[k]),
      .num_i   (num[k]),
      .div_i   (divisor_i),
      .valid_o (vld[k+1]),
      .side_o  (side[k+1]),
      .rem_o   (rem[k+1]),
      .num_o   (num[k+1])
    );
  end

  assign valid_o = vld[WIDTH];
  assign side_o  = side[WIDTH];
  assign quot_o  = num[WIDTH];
  assign rem_o   = rem[WIDTH];

endmodule

// ===== hdl/tensor_broadcast_index.sv =====
// Top level of the four-dimensional broadcast source index generator.
`timescale 1ns / 1ps

// Each transfer on start_i (tile number and element position) yields exactly one
// src_index_o with overflow_flag_o, shown for one cycle with done_o high. A new item
// is taken in every cycle and busy_o stays low. The pipeline holds three rows of
// INDEX_BITS restoring-division cells, one quotient bit per cell: the split by
// destination extents, the reduction of the middle coordinates, and the reduction by
// the source extents. The receiver cannot hold results off, so done_o must be taken
// when it comes. It is up to the user that register writes apply only to items
// started after the write; the block itself does not enforce it.
module tensor_broadcast_index #(
  parameter int INDEX_BITS = tbi_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [tbi_pkg::TILE_NUMBER_W-1:0]   tile_number_i,
  input  logic [tbi_pkg::ELEM_POSITION_W-1:0] elem_position_i,
  input  logic                                cfg_we_i,
  input  logic [tbi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tbi_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                done_o,
  output logic [tbi_pkg::SRC_INDEX_W-1:0]     src_index_o,
  output logic                                overflow_flag_o
);

  localparam int W   = INDEX_BITS;
  localparam int EW  = tbi_pkg::EXTENT_W;
  localparam int LAT = 3 * W + 5;
  localparam logic [30:0] LowMask =
      (W >= 31) ? {31{1'b1}} : 31'((64'd1 << W) - 64'd1);

  typedef struct packed {
    logic [30:0] lo;
    logic        ovf;
  } prod_t;

  // Low 31 bits of a product of held values, and whether the exact product
  // exceeds the safe limit.
  function automatic prod_t mul_chk(input logic [W-1:0] a, input logic [W-1:0] b);
    prod_t       r;
    logic        big_a;
    logic        big_b;
    logic [61:0] lp;
    big_a = (64'(a) > tbi_pkg::SAFE_LIMIT);
    big_b = (64'(b) > tbi_pkg::SAFE_LIMIT);
    lp    = 31'(a) * 31'(b);
    r.ovf = ((a != '0) && (b != '0) && (big_a || big_b)) ||
            (64'(lp) > tbi_pkg::SAFE_LIMIT);
    r.lo  = lp[30:0] & LowMask;
    return r;
  endfunction

  // Configuration registers.
  logic [tbi_pkg::TILE_LENGTH_W-1:0] tile_length_q;
  logic [EW-1:0]                     src_extent_q [4];
  logic [EW-1:0]                     dst_extent_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_length_q <= 21'd1;
      for (int k = 0; k < 4; k++) src_extent_q[k] <= 17'd1;
      for (int k = 0; k < 3; k++) dst_extent_q[k] <= 17'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbi_pkg::CFG_TILE_LENGTH:  tile_length_q   <= cfg_data_i;
        tbi_pkg::CFG_SRC_EXTENT_0: src_extent_q[0] <= cfg_data_i[EW-1:0];
        tbi_pkg::CFG_SRC_EXTENT_1: src_extent_q[1] <= cfg_data_i[EW-1:0];
        tbi_pkg::CFG_SRC_EXTENT_2: src_extent_q[2] <= cfg_data_i[EW-1:0];
        tbi_pkg::CFG_SRC_EXTENT_3: src_extent_q[3] <= cfg_data_i[EW-1:0];
        tbi_pkg::CFG_DST_EXTENT_0: dst_extent_q[0] <= cfg_data_i[EW-1:0];
        tbi_pkg::CFG_DST_EXTENT_1: dst_extent_q[1] <= cfg_data_i[EW-1:0];
        tbi_pkg::CFG_DST_EXTENT_2: dst_extent_q[2] <= cfg_data_i[EW-1:0];
        default: ;
      endcase
    end
  end

  // Register values as seen on the index width.
  logic [20:0]   tl_e;
  logic [EW-1:0] a_e [4];
  logic [EW-1:0] b_e [3];
  logic [W-1:0]  a_w [4];
  logic [W-1:0]  b_w [3];

  always_comb begin
    tl_e = 21'(W'(tile_length_q));
    for (int k = 0; k < 4; k++) begin
      a_e[k] = EW'(W'(src_extent_q[k]));
      a_w[k] = W'(a_e[k]);
    end
    for (int k = 0; k < 3; k++) begin
      b_e[k] = EW'(W'(dst_extent_q[k]));
      b_w[k] = W'(b_e[k]);
    end
  end

  // Contiguous strides, two multiply stages deep; they follow the registers.
  logic [2*EW-1:0] s2x_q, d2x_q;
  logic [W-1:0]    s2w_q, d2w_q;
  logic            s2f_q, d2f_q;
  logic [3*EW-1:0] s3x_q, d3x_q;
  logic [W-1:0]    s2w, d2w, s3w, d3w;
  logic            cfg_flag_q;

  assign s2w = W'(s2x_q);
  assign d2w = W'(d2x_q);
  assign s3w = W'(s3x_q);
  assign d3w = W'(d3x_q);

  always_ff @(posedge clk_i) begin
    s2x_q <= a_e[0] * a_e[1];
    d2x_q <= b_e[0] * b_e[1];
    s2w_q <= s2w;
    d2w_q <= d2w;
    s2f_q <= (64'(s2x_q) > tbi_pkg::SAFE_LIMIT);
    d2f_q <= (64'(d2x_q) > tbi_pkg::SAFE_LIMIT);
    s3x_q <= (2*EW)'(s2w) * a_e[2];
    d3x_q <= (2*EW)'(d2w) * b_e[2];
    // Stride overflow and any zero divisor mark every result.
    cfg_flag_q <= s2f_q || d2f_q ||
                  (64'(s3x_q) > tbi_pkg::SAFE_LIMIT) ||
                  (64'(d3x_q) > tbi_pkg::SAFE_LIMIT) ||
                  (b_w[0] == '0) || (b_w[1] == '0) || (b_w[2] == '0) ||
                  (d2w_q == '0) || (d3w == '0) ||
                  (a_w[0] == '0) || (a_w[1] == '0) || (a_w[2] == '0) || (a_w[3] == '0);
  end

  // Input register, tile product, then the global destination index.
  logic        a_vld_q, b_vld_q, c_vld_q;
  logic [30:0] tn_q;
  logic [19:0] pos_aq, pos_bq;
  logic [51:0] p_q;
  logic [W-1:0] pw;
  logic [W-1:0] g_q;
  logic         gf_q;

  assign pw = W'(p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i && !busy_o;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tn_q   <= 31'(W'(tile_number_i));
    pos_aq <= 20'(W'(elem_position_i));
    p_q    <= tn_q * tl_e;
    pos_bq <= pos_aq;
    g_q    <= pw + W'(pos_bq);
    gf_q   <= (64'(p_q) > tbi_pkg::SAFE_LIMIT) ||
              (64'(pw) > tbi_pkg::SAFE_LIMIT) ||
              ((64'(pw) + 64'(pos_bq)) > tbi_pkg::SAFE_LIMIT);
  end

  // Split by the destination extents: g / b0, g / d2, g / d3.
  logic              c1_vld;
  logic              c1_side;
  logic [2:0][W-1:0] c1_quot, c1_rem;

  tbi_chain #(
    .WIDTH  (W),
    .LANES  (3),
    .SIDE_W (1)
  ) u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (c_vld_q),
    .side_i     (gf_q),
    .dividend_i ({g_q, g_q, g_q}),
    .divisor_i  ({d3w, d2w_q, b_w[0]}),
    .valid_o    (c1_vld),
    .side_o     (c1_side),
    .quot_o     (c1_quot),
    .rem_o      (c1_rem)
  );

  // Middle coordinates reduced by their destination extents; i0 and i3 ride along.
  logic              c2_vld;
  logic [2*W:0]      c2_side;
  logic [1:0][W-1:0] c2_quot, c2_rem;

  tbi_chain #(
    .WIDTH  (W),
    .LANES  (2),
    .SIDE_W (2 * W + 1)
  ) u_coord (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (c1_vld),
    .side_i     ({c1_quot[2], c1_rem[0], c1_side}),
    .dividend_i ({c1_quot[1], c1_quot[0]}),
    .divisor_i  ({b_w[2], b_w[1]}),
    .valid_o    (c2_vld),
    .side_o     (c2_side),
    .quot_o     (c2_quot),
    .rem_o      (c2_rem)
  );

  // Broadcast: every coordinate reduced by its source extent.
  logic              c3_vld;
  logic              c3_side;
  logic [3:0][W-1:0] c3_quot, c3_rem;

  tbi_chain #(
    .WIDTH  (W),
    .LANES  (4),
    .SIDE_W (1)
  ) u_bcast (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (c2_vld),
    .side_i     (c2_side[0]),
    .dividend_i ({c2_side[2*W:W+1], c2_rem[1], c2_rem[0], c2_side[W:1]}),
    .divisor_i  ({a_w[3], a_w[2], a_w[1], a_w[0]}),
    .valid_o    (c3_vld),
    .side_o     (c3_side),
    .quot_o     (c3_quot),
    .rem_o      (c3_rem)
  );

  // Stride products. Once any flag is up only the low bits of the index matter,
  // and without a flag every held value is below 2^31, so 31 bits carry it all.
  prod_t       m1, m2, m3;
  logic        p_vld_q;
  logic [30:0] j0_q, m1_q, m2_q, m3_q;
  logic        pf_q;

  assign m1 = mul_chk(c3_rem[1], a_w[0]);
  assign m2 = mul_chk(c3_rem[2], s2w_q);
  assign m3 = mul_chk(c3_rem[3], s3w);

  always_ff @(posedge clk_i) begin
    j0_q <= 31'(c3_rem[0]) & LowMask;
    m1_q <= m1.lo;
    m2_q <= m2.lo;
    m3_q <= m3.lo;
    pf_q <= c3_side || m1.ovf || m2.ovf || m3.ovf;
  end

  // Accumulate the terms and register the result.
  logic [31:0] sum1, sum2, sum3;
  logic        done_q;
  logic [30:0] src_index_q;
  logic        ovf_q;

  assign sum1 = {1'b0, j0_q} + {1'b0, m1_q};
  assign sum2 = {1'b0, sum1[30:0] & LowMask} + {1'b0, m2_q};
  assign sum3 = {1'b0, sum2[30:0] & LowMask} + {1'b0, m3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      p_vld_q <= c3_vld;
      done_q  <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    src_index_q <= sum3[30:0] & LowMask;
    ovf_q       <= pf_q || sum1[31] || sum2[31] || sum3[31] || cfg_flag_q;
  end

  assign busy_o          = 1'b0;
  assign done_o          = done_q;
  assign src_index_o     = src_index_q;
  assign overflow_flag_o = ovf_q;

`ifndef SYNTHESIS
  // Every accepted item comes out after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted item did not complete after the pipeline latency");

  // No result without an item accepted the latency before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without a matching accepted item");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the four-dimensional broadcast source index generator.
`timescale 1ns / 1ps

module tb_top;

  localparam int IDX_BITS     = 32;
  localparam int LATENCY      = 3 * IDX_BITS + 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [63:0] IDX_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - IDX_BITS);

  // Register indexes past the last register; writes to them are ignored.
  localparam logic [tbi_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd8;
  localparam logic [tbi_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [tbi_pkg::SRC_INDEX_W-1:0] src_index;
    logic                            overflow_flag;
  } src_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start_i = 1'b0;
  logic [tbi_pkg::TILE_NUMBER_W-1:0]   tile_number_i = '0;
  logic [tbi_pkg::ELEM_POSITION_W-1:0] elem_position_i = '0;
  logic                                cfg_we_i = 1'b0;
  logic [tbi_pkg::CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [tbi_pkg::CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                                busy_o;
  logic                                done_o;
  logic [tbi_pkg::SRC_INDEX_W-1:0]     src_index_o;
  logic                                overflow_flag_o;

  // Shadow copy of the configuration registers.
  logic [tbi_pkg::TILE_LENGTH_W-1:0] shadow_tile_len = 1;
  logic [tbi_pkg::EXTENT_W-1:0]      shadow_src_ext [4] = '{1, 1, 1, 1};
  logic [tbi_pkg::EXTENT_W-1:0]      shadow_dst_ext [3] = '{1, 1, 1};

  src_result_t pending_results[$];
  int          error_count = 0;
  int          cycle_count = 0;

  tensor_broadcast_index #(.INDEX_BITS(IDX_BITS)) dut (.*);

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Index arithmetic with overflow tracking.
  function automatic logic [63:0] idx_mul(input logic [63:0] a, input logic [63:0] b,
                                          inout logic flag);
    if (a != 0 && b > tbi_pkg::SAFE_LIMIT / a) flag = 1'b1;
    return (a * b) & IDX_MASK;
  endfunction

  function automatic logic [63:0] idx_add(input logic [63:0] a, input logic [63:0] b,
                                          inout logic flag);
    if (a > tbi_pkg::SAFE_LIMIT || b > tbi_pkg::SAFE_LIMIT - a) flag = 1'b1;
    return (a + b) & IDX_MASK;
  endfunction

  function automatic logic [63:0] idx_div(input logic [63:0] a, input logic [63:0] b,
                                          inout logic flag);
    if (b == 0) begin
      flag = 1'b1;
      return IDX_MASK;
    end
    return a / b;
  endfunction

  function automatic logic [63:0] idx_mod(input logic [63:0] a, input logic [63:0] b,
                                          inout logic flag);
    if (b == 0) begin
      flag = 1'b1;
      return a;
    end
    return a % b;
  endfunction

  // Source index of one destination element under the shadow configuration.
  function automatic src_result_t predict_src_index(
      input logic [tbi_pkg::TILE_NUMBER_W-1:0] tn,
      input logic [tbi_pkg::ELEM_POSITION_W-1:0] pos);
    logic        flag;
    logic [63:0] a [4];
    logic [63:0] b [3];
    logic [63:0] gidx, s2, s3, d2, d3, acc;
    logic [63:0] c [4];
    src_result_t res;
    flag = 1'b0;
    for (int k = 0; k < 4; k++) a[k] = 64'(shadow_src_ext[k]) & IDX_MASK;
    for (int k = 0; k < 3; k++) b[k] = 64'(shadow_dst_ext[k]) & IDX_MASK;
    gidx = idx_add(idx_mul(64'(tn) & IDX_MASK, 64'(shadow_tile_len) & IDX_MASK, flag),
                   64'(pos) & IDX_MASK, flag);
    s2 = idx_mul(a[0], a[1], flag);
    s3 = idx_mul(s2, a[2], flag);
    d2 = idx_mul(b[0], b[1], flag);
    d3 = idx_mul(d2, b[2], flag);
    c[0] = idx_mod(gidx, b[0], flag);
    c[1] = idx_mod(idx_div(gidx, b[0], flag), b[1], flag);
    c[2] = idx_mod(idx_div(gidx, d2, flag), b[2], flag);
    c[3] = idx_div(gidx, d3, flag);
    for (int k = 0; k < 4; k++) c[k] = idx_mod(c[k], a[k], flag);
    acc = idx_add(c[0], idx_mul(c[1], a[0], flag), flag);
    acc = idx_add(acc, idx_mul(c[2], s2, flag), flag);
    acc = idx_add(acc, idx_mul(c[3], s3, flag), flag);
    res.src_index = acc[tbi_pkg::SRC_INDEX_W-1:0];
    res.overflow_flag = flag;
    return res;
  endfunction

  // Result checker: every strobe is compared with the oldest expected transfer.
  always @(posedge clk_i) begin
    src_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result src_index=%0d overflow_flag=%0b", src_index_o,
               overflow_flag_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (src_index_o !== exp_res.src_index) begin
          $error("src_index expected %0d actual %0d", exp_res.src_index, src_index_o);
          error_count++;
        end
        if (overflow_flag_o !== exp_res.overflow_flag) begin
          $error("overflow_flag expected %0b actual %0b", exp_res.overflow_flag,
                 overflow_flag_o);
          error_count++;
        end
      end
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Send one item and record its expected result once the transfer happens.
  task automatic send_item(input logic [tbi_pkg::TILE_NUMBER_W-1:0] tn,
                           input logic [tbi_pkg::ELEM_POSITION_W-1:0] pos, input int gap);
    start_i <= 1'b1;
    tile_number_i <= tn;
    elem_position_i <= pos;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_src_index(tn, pos));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write a set of registers while the block is idle.
  task automatic write_regs(input logic [tbi_pkg::CFG_IDX_W-1:0] idxs[$],
                            input logic [tbi_pkg::CFG_DATA_W-1:0] vals[$]);
    drain_results();
    foreach (idxs[k]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idxs[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      case (idxs[k])
        tbi_pkg::CFG_TILE_LENGTH:  shadow_tile_len   = vals[k][tbi_pkg::TILE_LENGTH_W-1:0];
        tbi_pkg::CFG_SRC_EXTENT_0: shadow_src_ext[0] = vals[k][tbi_pkg::EXTENT_W-1:0];
        tbi_pkg::CFG_SRC_EXTENT_1: shadow_src_ext[1] = vals[k][tbi_pkg::EXTENT_W-1:0];
        tbi_pkg::CFG_SRC_EXTENT_2: shadow_src_ext[2] = vals[k][tbi_pkg::EXTENT_W-1:0];
        tbi_pkg::CFG_SRC_EXTENT_3: shadow_src_ext[3] = vals[k][tbi_pkg::EXTENT_W-1:0];
        tbi_pkg::CFG_DST_EXTENT_0: shadow_dst_ext[0] = vals[k][tbi_pkg::EXTENT_W-1:0];
        tbi_pkg::CFG_DST_EXTENT_1: shadow_dst_ext[1] = vals[k][tbi_pkg::EXTENT_W-1:0];
        tbi_pkg::CFG_DST_EXTENT_2: shadow_dst_ext[2] = vals[k][tbi_pkg::EXTENT_W-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all eight registers in index order.
  task automatic write_all(input logic [tbi_pkg::CFG_DATA_W-1:0] tl,
                           input logic [tbi_pkg::CFG_DATA_W-1:0] s0,
                           input logic [tbi_pkg::CFG_DATA_W-1:0] s1,
                           input logic [tbi_pkg::CFG_DATA_W-1:0] s2,
                           input logic [tbi_pkg::CFG_DATA_W-1:0] s3,
                           input logic [tbi_pkg::CFG_DATA_W-1:0] d0,
                           input logic [tbi_pkg::CFG_DATA_W-1:0] d1,
                           input logic [tbi_pkg::CFG_DATA_W-1:0] d2);
    write_regs('{tbi_pkg::CFG_TILE_LENGTH, tbi_pkg::CFG_SRC_EXTENT_0,
                 tbi_pkg::CFG_SRC_EXTENT_1, tbi_pkg::CFG_SRC_EXTENT_2,
                 tbi_pkg::CFG_SRC_EXTENT_3, tbi_pkg::CFG_DST_EXTENT_0,
                 tbi_pkg::CFG_DST_EXTENT_1, tbi_pkg::CFG_DST_EXTENT_2},
               '{tl, s0, s1, s2, s3, d0, d1, d2});
  endtask

  // Extremes of the fields under reset and a small broadcast configuration.
  task automatic test_directed();
    send_item(0, 0, 0);
    send_item('1, '1, 0);
    send_item(5, 0, 1);
    write_all(4, 1, 3, 1, 2, 4, 3, 2);
    for (int k = 0; k < 6; k++) send_item(31'(k), 20'(k % 4), 0);
    // Element position past the end of the tile.
    send_item(2, 9, 0);
    send_item(0, '1, 0);
    send_item('1, 0, 2);
    // Writes to indexes above seven must leave the configuration alone.
    write_regs('{CFG_SPARE_LO, CFG_SPARE_HI}, '{21'd7, '1});
    send_item(3, 1, 0);
    // Zero tile length and zero extents.
    write_all(0, 0, 2, 0, 3, 0, 2, 0);
    send_item(7, 5, 0);
    send_item(0, 0, 0);
    // Extremes of every register, including bits above the extent width.
    write_all(1048576, 65536, 65536, 65536, 65536, 65536, 65536, 65536);
    send_item(0, 12345, 0);
    send_item(1, 0, 0);
    write_all('1, '1, '1, '1, '1, '1, '1, '1);
    send_item(1, '1, 0);
    send_item(0, 3, 0);
  endtask

  // One random phase: a fresh configuration and mostly well-formed tile traffic.
  task automatic test_random_phase(input int n_items, input bit no_gaps);
    int tl, dst [3], src [4], mode, tn_max;
    tl = ($urandom_range(9) == 0) ? 1048576 : $urandom_range(64, 1);
    for (int k = 0; k < 3; k++) dst[k] = $urandom_range(16, 1);
    for (int k = 0; k < 4; k++) begin
      mode = $urandom_range(2);
      if (k == 3) src[k] = $urandom_range(8, 1);
      else if (mode == 0) src[k] = 1;
      else if (mode == 1) src[k] = dst[k];
      else src[k] = $urandom_range(dst[k], 1);
    end
    write_all(21'(tl), 21'(src[0]), 21'(src[1]), 21'(src[2]), 21'(src[3]),
              21'(dst[0]), 21'(dst[1]), 21'(dst[2]));
    tn_max = (tl > 4096) ? 2000 : 4000;
    for (int n = 0; n < n_items; n++) begin
      logic [tbi_pkg::TILE_NUMBER_W-1:0]   tn;
      logic [tbi_pkg::ELEM_POSITION_W-1:0] pos;
      if ($urandom_range(9) == 0) begin
        tn = 31'($urandom);
        pos = 20'($urandom);
      end else begin
        tn = 31'($urandom_range(tn_max));
        pos = 20'($urandom_range(tl - 1));
      end
      send_item(tn, pos, no_gaps ? 0 : pick_gap());
      // Halfway through, hold off until every expected result is back.
      if (n == n_items / 2) drain_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int p = 0; p < 8; p++) test_random_phase(190, p == 3);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
